### rtl/core/cbpm_pkg.sv
// ---------------------------------------------------------------------------
// cbpm_pkg
// Shared constants, codes, types and helpers of the chained block pool
// manager: pool size, field widths, request kinds, status codes and the
// structs that run between the sequencer, the link memory and the divider.
// ---------------------------------------------------------------------------
package cbpm_pkg;

   // pool geometry
   localparam int NUM_BLOCKS = 64;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

   // field widths
   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 20;
   localparam int BS_W     = 16;
   localparam int STATUS_W = 3;
   localparam int STEP_W   = $clog2(SIZE_W + 1);

   localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_BLOCKS);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LIST  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_DESC   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_BLOCK_SIZE = 3'd0;

   // link memory access
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } link_rd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } link_wr_type;

   // ceiling divider handshake
   typedef struct packed {
      logic              start;
      logic [SIZE_W-1:0] dividend;
      logic [BS_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] quotient;
      logic              rem_nz;
   } div_rsp_type;

   // pool occupancy seen by the top level
   typedef struct packed {
      logic [CNT_W-1:0] free_total;
      logic [CNT_W-1:0] desc_total;
   } pool_stat_type;

   // next index around the pool
   function automatic logic [IDX_W-1:0] bump_idx(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] nxt;
      nxt = (p == IDX_W'(NUM_BLOCKS - 1)) ? '0 : IDX_W'(p + 1'b1);
      return nxt;
   endfunction

endpackage

### rtl/core/cbpm_ceil_div.sv
// ---------------------------------------------------------------------------
// cbpm_ceil_div
// Restoring divider, one quotient bit per cycle, for the block count of an
// allocation. Reports the quotient and whether a remainder is left.
// ---------------------------------------------------------------------------
module cbpm_ceil_div
   import cbpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [BS_W-1:0]   rem_ff, rem_in;
   logic [BS_W-1:0]   div_ff, div_in;
   logic [BS_W:0]     trial;
   logic [BS_W:0]     diff;
   logic              ge;

   // load on start, else one restoring step while busy
   always_comb begin
      trial   = {rem_ff, quo_ff[SIZE_W-1]};
      ge      = (trial >= {1'b0, div_ff});
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(SIZE_W);
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SIZE_W-2:0], ge};
         rem_in = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.rem_nz   = (rem_ff != '0);

endmodule

### rtl/core/cbpm_link_mem.sv
// ---------------------------------------------------------------------------
// cbpm_link_mem
// Per-block link memory, one read and one write port, registered read.
// An entry never written reads as the next index, which gives the free list
// in index order after reset.
// ---------------------------------------------------------------------------
module cbpm_link_mem
   import cbpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  link_rd_type      rd,
   input  link_wr_type      wr,
   output logic [IDX_W-1:0] q
);

   logic [IDX_W-1:0]      mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] vld_ff;
   logic [IDX_W-1:0]      q_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic                  hit_ff;

   // written marks
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         q_ff    <= mem[rd.addr];
         addr_ff <= rd.addr;
         hit_ff  <= vld_ff[rd.addr];
      end
   end

   assign q = hit_ff ? q_ff : bump_idx(addr_ff);

endmodule

### rtl/core/cbpm_ctrl.sv
// ---------------------------------------------------------------------------
// cbpm_ctrl
// Request sequencer: descriptor queue, chain table, in-use flags, free
// list and result registers. Walks chains one link per cycle unless stalled.
// ---------------------------------------------------------------------------
module cbpm_ctrl
   import cbpm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [BS_W-1:0]     block_size,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [IDX_W-1:0]    req_packet_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_granted_packet,
   output logic [IDX_W-1:0]    rsp_block_index,
   output logic [CNT_W-1:0]    rsp_block_count,
   output logic                rsp_last,
   output link_rd_type         link_rd,
   output link_wr_type         link_wr,
   input  logic [IDX_W-1:0]    link_q,
   output div_req_type         div_req,
   input  div_rsp_type         div_rsp,
   output pool_stat_type       stat
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_WALK, S_CHAIN, S_LIST, S_EMIT
   } state_type;

   localparam int CHAIN_W = 2 * IDX_W + CNT_W;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]      rsp_pkt_ff, rsp_pkt_in;
   logic [IDX_W-1:0]      rsp_blk_ff, rsp_blk_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [IDX_W-1:0]      res_pkt_ff, res_pkt_in;
   logic [IDX_W-1:0]      res_blk_ff, res_blk_in;
   logic [CNT_W-1:0]      res_cnt_ff, res_cnt_in;
   logic [IDX_W-1:0]      free_head_ff, free_head_in;
   logic [IDX_W-1:0]      free_tail_ff, free_tail_in;
   logic [CNT_W-1:0]      free_total_ff, free_total_in;
   logic [IDX_W-1:0]      desc_rp_ff, desc_rp_in;
   logic [IDX_W-1:0]      desc_wp_ff, desc_wp_in;
   logic [CNT_W-1:0]      desc_total_ff, desc_total_in;
   logic [NUM_BLOCKS-1:0] in_use_ff, in_use_in;
   logic [NUM_BLOCKS-1:0] desc_vld_ff, desc_vld_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [IDX_W-1:0]      pid_ff, pid_in;
   logic [CNT_W-1:0]      need_ff, need_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      fin_ff, fin_in;
   logic [IDX_W-1:0]      b_ff, b_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic                  fetch_ff, fetch_in;

   // descriptor queue and chain table
   logic [IDX_W-1:0]      desc_mem [NUM_BLOCKS];
   logic [IDX_W-1:0]      desc_q_ff;
   logic [IDX_W-1:0]      desc_addr_ff;
   logic                  desc_hit_ff;
   logic [CHAIN_W-1:0]    chain_mem [NUM_BLOCKS];
   logic [CHAIN_W-1:0]    chain_q_ff;

   logic                  desc_re, desc_we, chain_re, chain_we;
   logic [IDX_W-1:0]      chain_waddr;
   logic [CHAIN_W-1:0]    chain_wdata;
   logic [IDX_W-1:0]      desc_d;
   logic [IDX_W-1:0]      cf, cfin;
   logic [CNT_W-1:0]      clen;
   logic [SIZE_W:0]       need_full;
   logic [IDX_W-1:0]      b_eff;
   logic                  out_free;

   assign desc_d = desc_hit_ff ? desc_q_ff : desc_addr_ff;
   assign {cf, cfin, clen} = chain_q_ff;
   assign need_full = {1'b0, div_rsp.quotient} + {{SIZE_W{1'b0}}, div_rsp.rem_nz};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b_eff = fetch_ff ? link_q : b_ff;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pkt_in    = rsp_pkt_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      res_status_in = res_status_ff;
      res_pkt_in    = res_pkt_ff;
      res_blk_in    = res_blk_ff;
      res_cnt_in    = res_cnt_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_total_in = free_total_ff;
      desc_rp_in    = desc_rp_ff;
      desc_wp_in    = desc_wp_ff;
      desc_total_in = desc_total_ff;
      in_use_in     = in_use_ff;
      desc_vld_in   = desc_vld_ff;
      kind_in       = kind_ff;
      pid_in        = pid_ff;
      need_in       = need_ff;
      cnt_in        = cnt_ff;
      fin_in        = fin_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      fetch_in      = fetch_ff;
      link_rd       = '0;
      link_wr       = '0;
      div_req       = '0;
      desc_re       = 1'b0;
      desc_we       = 1'b0;
      chain_re      = 1'b0;
      chain_we      = 1'b0;
      chain_waddr   = desc_d;
      chain_wdata   = {free_head_ff, fin_ff, need_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               pid_in     = req_packet_id;
               res_pkt_in = req_packet_id;
               res_blk_in = '0;
               res_cnt_in = '0;
               case (req_kind)
                  KIND_ALLOC: begin
                     if (req_request_size == '0) begin
                        res_status_in = ST_ZERO_SIZE;
                        state_in      = S_EMIT;
                     end else if (desc_total_ff == '0) begin
                        res_status_in = ST_NO_DESC;
                        state_in      = S_EMIT;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = req_request_size;
                        div_req.divisor  = (block_size == '0) ? BS_W'(1) : block_size;
                        desc_re          = 1'b1;
                        state_in         = S_DIV;
                     end
                  end
                  KIND_FREE, KIND_LIST: begin
                     if (!in_use_ff[req_packet_id]) begin
                        res_status_in = ST_NOT_ALLOC;
                        state_in      = S_EMIT;
                     end else begin
                        chain_re = 1'b1;
                        state_in = S_CHAIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // block count known: check stock, start the walk at the head
         S_DIV: begin
            if (div_rsp.done) begin
               if (need_full > {{(SIZE_W + 1 - CNT_W){1'b0}}, free_total_ff}) begin
                  res_status_in = ST_SHORT;
                  state_in      = S_EMIT;
               end else begin
                  need_in      = need_full[CNT_W-1:0];
                  fin_in       = free_head_ff;
                  link_rd.en   = 1'b1;
                  link_rd.addr = free_head_ff;
                  cnt_in       = CNT_W'(1);
                  state_in     = S_WALK;
               end
            end
         end
         // one link per cycle until the new free head is known
         S_WALK: begin
            if (cnt_ff == need_ff) begin
               chain_we            = 1'b1;
               in_use_in[desc_d]   = 1'b1;
               desc_rp_in          = bump_idx(desc_rp_ff);
               desc_total_in       = desc_total_ff - 1'b1;
               free_head_in        = link_q;
               free_total_in       = free_total_ff - need_ff;
               res_status_in       = ST_OK;
               res_pkt_in          = desc_d;
               res_blk_in          = free_head_ff;
               res_cnt_in          = need_ff;
               state_in            = S_EMIT;
            end else begin
               fin_in       = link_q;
               link_rd.en   = 1'b1;
               link_rd.addr = link_q;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         S_CHAIN: begin
            if (kind_ff == KIND_FREE) begin
               // append chain to the free list, descriptor to its queue
               if (free_total_ff == '0) begin
                  free_head_in = cf;
               end else begin
                  link_wr.en   = 1'b1;
                  link_wr.addr = free_tail_ff;
                  link_wr.data = cf;
               end
               free_tail_in          = cfin;
               free_total_in         = free_total_ff + clen;
               desc_we               = 1'b1;
               desc_vld_in[desc_wp_ff] = 1'b1;
               desc_wp_in            = bump_idx(desc_wp_ff);
               desc_total_in         = desc_total_ff + 1'b1;
               in_use_in[pid_ff]     = 1'b0;
               res_status_in         = ST_OK;
               res_blk_in            = cf;
               res_cnt_in            = clen;
               state_in              = S_EMIT;
            end else if (clen == '0) begin
               res_status_in = ST_OK;
               state_in      = S_EMIT;
            end else begin
               b_in     = cf;
               k_in     = clen;
               len_in   = clen;
               fetch_in = 1'b0;
               state_in = S_LIST;
            end
         end
         // one listed block per beat
         S_LIST: begin
            b_in     = b_eff;
            fetch_in = 1'b0;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_pkt_in    = pid_ff;
               rsp_blk_in    = b_eff;
               rsp_cnt_in    = len_ff;
               rsp_last_in   = (k_ff == CNT_W'(1));
               if (k_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  link_rd.en   = 1'b1;
                  link_rd.addr = b_eff;
                  fetch_in     = 1'b1;
                  k_in         = k_ff - 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pkt_in    = res_pkt_ff;
               rsp_blk_in    = res_blk_ff;
               rsp_cnt_in    = res_cnt_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_head_ff  <= '0;
         free_tail_ff  <= IDX_W'(NUM_BLOCKS - 1);
         free_total_ff <= NUM_CNT;
         desc_rp_ff    <= '0;
         desc_wp_ff    <= '0;
         desc_total_ff <= NUM_CNT;
         in_use_ff     <= '0;
         desc_vld_ff   <= '0;
         fetch_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_total_ff <= free_total_in;
         desc_rp_ff    <= desc_rp_in;
         desc_wp_ff    <= desc_wp_in;
         desc_total_ff <= desc_total_in;
         in_use_ff     <= in_use_in;
         desc_vld_ff   <= desc_vld_in;
         fetch_ff      <= fetch_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pkt_ff    <= rsp_pkt_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
      res_status_ff <= res_status_in;
      res_pkt_ff    <= res_pkt_in;
      res_blk_ff    <= res_blk_in;
      res_cnt_ff    <= res_cnt_in;
      kind_ff       <= kind_in;
      pid_ff        <= pid_in;
      need_ff       <= need_in;
      cnt_ff        <= cnt_in;
      fin_ff        <= fin_in;
      b_ff          <= b_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
   end

   // descriptor queue memory, unwritten entries read as their index
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[desc_wp_ff] <= pid_ff;
      end
      if (desc_re) begin
         desc_q_ff    <= desc_mem[desc_rp_ff];
         desc_addr_ff <= desc_rp_ff;
         desc_hit_ff  <= desc_vld_ff[desc_rp_ff];
      end
   end

   // chain table memory
   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_waddr] <= chain_wdata;
      end
      if (chain_re) begin
         chain_q_ff <= chain_mem[req_packet_id];
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_packet = rsp_pkt_ff;
   assign rsp_block_index    = rsp_blk_ff;
   assign rsp_block_count    = rsp_cnt_ff;
   assign rsp_last           = rsp_last_ff;
   assign stat.free_total    = free_total_ff;
   assign stat.desc_total    = desc_total_ff;

endmodule

### rtl/core/chained_block_pool_manager.sv
// ---------------------------------------------------------------------------
// chained_block_pool_manager
// Pool of fixed-size blocks and packet descriptors kept in free lists.
//
// Request channel (req_*): one beat per command: allocate, free or list.
// A kind of 3 is dropped without a result. Result channel (rsp_*): one beat
// per allocate or free, one beat per chained block for a list; rsp_last
// marks the final beat of a command. Errors always give a single beat.
// Throughput: one command at a time. Allocate runs the start and the 20
// steps of the bit-serial divider for the block count, walks the free list
// through the link memory, then commits and loads the result beat. List
// gives one beat per link read.
// Reset: synchronous; after it every block is free in index order, every
// descriptor is queued in index order and block_size reads 64. No clearing
// pass is needed. A stall on rsp holds the result register and pauses a
// list walk; one finished beat may wait while the next command is taken.
// csr: APB-style, block_size at byte address 0, pready always high.
// ---------------------------------------------------------------------------
module chained_block_pool_manager
   import cbpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic [IDX_W-1:0]      req_packet_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]      rsp_granted_packet,
   output logic [IDX_W-1:0]      rsp_block_index,
   output logic [CNT_W-1:0]      rsp_block_count,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [BS_W-1:0] block_size_ff;
   link_rd_type     link_rd;
   link_wr_type     link_wr;
   logic [IDX_W-1:0] link_q;
   div_req_type     div_req;
   div_rsp_type     div_rsp;
   pool_stat_type   stat;
   logic            csr_wr;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BS_W'(64);
      end else if (csr_wr && (csr_paddr == REG_BLOCK_SIZE)) begin
         block_size_ff <= csr_pwdata[BS_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == REG_BLOCK_SIZE) ? {{(32 - BS_W){1'b0}}, block_size_ff}
                                                     : '0;

   cbpm_ceil_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cbpm_link_mem u_link (
      .clock (clock),
      .reset (reset),
      .rd    (link_rd),
      .wr    (link_wr),
      .q     (link_q)
   );

   cbpm_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .block_size         (block_size_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_request_size   (req_request_size),
      .req_packet_id      (req_packet_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_packet (rsp_granted_packet),
      .rsp_block_index    (rsp_block_index),
      .rsp_block_count    (rsp_block_count),
      .rsp_last           (rsp_last),
      .link_rd            (link_rd),
      .link_wr            (link_wr),
      .link_q             (link_q),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .stat               (stat)
   );

   // pool counters never exceed the pool size
   a_totals_bounded: assert property (@(posedge clock) disable iff (reset)
      (stat.free_total <= NUM_CNT) && (stat.desc_total <= NUM_CNT))
      else $error("pool counter above pool size");

   // only a listing gives non-final beats, and those are always ok
   a_multi_beat_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_OK))
      else $error("non-final beat with error status");

   // a real command blocks the request channel in the next cycle
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_kind != KIND_NONE)) |=> req_stall)
      else $error("command taken without going busy");

   // a failed command carries no blocks
   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_block_count == '0) && rsp_last))
      else $error("error beat with block count");

endmodule

### bench/chained_block_pool_manager_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// chained_block_pool_manager_tb
// Drives allocate, free and list commands into the pool manager and checks
// every result beat against a behavioral model of the free block list, the
// descriptor queue and the per-packet chains. block_size is rewritten over
// the csr port between phases.
// ---------------------------------------------------------------------------
module chained_block_pool_manager_tb;
   import cbpm_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_packet;
      logic [IDX_W-1:0]    block_index;
      logic [CNT_W-1:0]    block_count;
      logic                last;
   } pool_beat_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] size;
      logic [IDX_W-1:0]  pid;
      bit                typed;
      logic [STATUS_W-1:0] st;
   } cmd_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [SIZE_W-1:0] req_request_size = '0;
   logic [IDX_W-1:0]  req_packet_id = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_granted_packet;
   logic [IDX_W-1:0]    rsp_block_index;
   logic [CNT_W-1:0]    rsp_block_count;
   logic                rsp_last;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   chained_block_pool_manager u_dut (.*);

   // model state
   logic [15:0]      bsize;
   logic [IDX_W-1:0] link_m [NUM_BLOCKS];
   logic [IDX_W-1:0] fhead, ftail;
   int               ftotal;
   logic [IDX_W-1:0] dq [NUM_BLOCKS];
   logic [IDX_W-1:0] drd, dwr;
   int               dtotal;
   logic [IDX_W-1:0] cfirst [NUM_BLOCKS];
   logic [IDX_W-1:0] cfinal [NUM_BLOCKS];
   int               clen [NUM_BLOCKS];
   bit               busy [NUM_BLOCKS];

   pool_beat_type expected_beats[$];
   int  errors = 0;
   int  send_idle = 0, recv_idle = 0;
   bit  hold_rsp = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL chained_block_pool_manager");
      $finish;
   end

   function automatic void pool_reset();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         link_m[i] = IDX_W'(i + 1);
         dq[i] = IDX_W'(i);
         busy[i] = 0;
      end
      bsize = 16'd64;
      fhead = '0;
      ftail = IDX_W'(NUM_BLOCKS - 1);
      ftotal = NUM_BLOCKS;
      drd = '0;
      dwr = '0;
      dtotal = NUM_BLOCKS;
   endfunction

   function automatic void push_beat(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] p,
                                     logic [IDX_W-1:0] b, int n, logic l);
      pool_beat_type r;
      r.status = st;
      r.granted_packet = p;
      r.block_index = b;
      r.block_count = CNT_W'(n);
      r.last = l;
      expected_beats.push_back(r);
   endfunction

   // predict the beats of one command and update the pool
   function automatic void pool_predict(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                                        logic [IDX_W-1:0] pid);
      int bs, need;
      logic [IDX_W-1:0] d, fin, b;
      if (k == KIND_ALLOC) begin
         bs = (bsize == 0) ? 1 : bsize;
         if (sz == 0) push_beat(ST_ZERO_SIZE, pid, '0, 0, 1);
         else if (dtotal == 0) push_beat(ST_NO_DESC, pid, '0, 0, 1);
         else begin
            need = (sz + bs - 1) / bs;
            if (need > ftotal) push_beat(ST_SHORT, pid, '0, 0, 1);
            else begin
               d = dq[drd];
               drd = bump_idx(drd);
               dtotal--;
               fin = fhead;
               for (int i = 1; i < need; i++) fin = link_m[fin];
               cfirst[d] = fhead;
               cfinal[d] = fin;
               clen[d] = need;
               busy[d] = 1;
               fhead = link_m[fin];
               ftotal -= need;
               push_beat(ST_OK, d, cfirst[d], need, 1);
            end
         end
      end else if (k == KIND_FREE || k == KIND_LIST) begin
         if (!busy[pid]) push_beat(ST_NOT_ALLOC, pid, '0, 0, 1);
         else if (k == KIND_FREE) begin
            if (ftotal == 0) fhead = cfirst[pid];
            else link_m[ftail] = cfirst[pid];
            ftail = cfinal[pid];
            ftotal += clen[pid];
            dq[dwr] = pid;
            dwr = bump_idx(dwr);
            dtotal++;
            busy[pid] = 0;
            push_beat(ST_OK, pid, cfirst[pid], clen[pid], 1);
         end else begin
            b = cfirst[pid];
            for (int i = 0; i < clen[pid]; i++) begin
               push_beat(ST_OK, pid, b, clen[pid], (i + 1 == clen[pid]));
               b = link_m[b];
            end
         end
      end
   endfunction

   task automatic csr_write(logic [15:0] v);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= REG_BLOCK_SIZE;
      csr_pwdata <= {16'($urandom_range(0, 65535)), v};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      bsize = v;
      // read back
      @(negedge clock);
      csr_psel <= 1;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      if (rd[15:0] !== v) begin
         $error("block_size readback expected %0d actual %0d", v, rd[15:0]);
         errors++;
      end
   endtask

   // one request beat; valid stays high across back-to-back beats
   task automatic send_cmd(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                           logic [IDX_W-1:0] pid);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_request_size <= sz;
      req_packet_id <= pid;
      pool_predict(k, sz, pid);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      req_valid <= 0;
      guard = 0;
      while (expected_beats.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (100) @(negedge clock);
   endtask

   // result side stall pattern
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_rsp || ($urandom_range(0, 99) < recv_idle);
   end

   // compare result beats
   always @(posedge clock) begin
      pool_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat status %0d", rsp_status);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status); errors++;
            end
            if (rsp_granted_packet !== e.granted_packet) begin
               $error("granted_packet expected %0d actual %0d",
                      e.granted_packet, rsp_granted_packet); errors++;
            end
            if (rsp_block_index !== e.block_index) begin
               $error("block_index expected %0d actual %0d",
                      e.block_index, rsp_block_index); errors++;
            end
            if (rsp_block_count !== e.block_count) begin
               $error("block_count expected %0d actual %0d",
                      e.block_count, rsp_block_count); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // directed table; typed status checked against the predicted single beat
   cmd_row_type dir_rows[$];

   task automatic add_row(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                          logic [IDX_W-1:0] p, bit t, logic [STATUS_W-1:0] s);
      cmd_row_type r;
      r.kind = k; r.size = sz; r.pid = p; r.typed = t; r.st = s;
      dir_rows.push_back(r);
   endtask

   // random well-formed traffic: mostly alloc/list/free of live packets
   task automatic random_phase(int n);
      int kd, hi;
      logic [IDX_W-1:0] pid;
      logic [SIZE_W-1:0] sz;
      for (int i = 0; i < n; i++) begin
         kd = $urandom_range(0, 99);
         pid = IDX_W'($urandom);
         for (int j = 0; j < 4 && !busy[pid]; j++) pid = IDX_W'($urandom);
         hi = (bsize == 0 ? 1 : bsize) * 6;
         if ($urandom_range(0, 19) == 0) sz = SIZE_W'($urandom);
         else sz = SIZE_W'($urandom_range(1, hi > 1048575 ? 1048575 : hi));
         if (kd < 40) send_cmd(KIND_ALLOC, sz, pid);
         else if (kd < 70) send_cmd(KIND_FREE, sz, pid);
         else if (kd < 95) send_cmd(KIND_LIST, sz, pid);
         else send_cmd(KIND_NONE, sz, pid);
      end
   endtask

   initial begin
      logic [15:0] sizes [4];
      pool_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // after reset, extremes and error codes
      add_row(KIND_FREE,  '0, 6'd0, 1, ST_NOT_ALLOC);
      add_row(KIND_LIST,  '0, 6'd63, 1, ST_NOT_ALLOC);
      add_row(KIND_ALLOC, '0, 6'd5, 1, ST_ZERO_SIZE);
      add_row(KIND_ALLOC, 20'hFFFFF, 6'd0, 1, ST_SHORT);
      add_row(KIND_ALLOC, 20'd1, 6'd0, 1, ST_OK);
      add_row(KIND_ALLOC, 20'd65, 6'd0, 0, ST_OK);
      add_row(KIND_ALLOC, 20'd128, 6'd0, 0, ST_OK);
      add_row(KIND_LIST,  '0, 6'd1, 0, ST_OK);
      add_row(KIND_NONE,  20'hFFFFF, 6'h3F, 0, ST_OK);
      add_row(KIND_FREE,  '0, 6'd1, 0, ST_OK);
      add_row(KIND_LIST,  '0, 6'd1, 1, ST_NOT_ALLOC);
      add_row(KIND_ALLOC, 20'd4096, 6'd0, 0, ST_OK);
      add_row(KIND_LIST,  '0, 6'd3, 0, ST_OK);
      add_row(KIND_ALLOC, 20'd64, 6'd0, 0, ST_OK);
      add_row(KIND_FREE,  '0, 6'd0, 0, ST_OK);
      add_row(KIND_FREE,  '0, 6'd2, 0, ST_OK);
      add_row(KIND_FREE,  '0, 6'd3, 0, ST_OK);
      add_row(KIND_FREE,  '0, 6'd4, 0, ST_OK);
      add_row(KIND_ALLOC, 20'd4096, 6'd0, 0, ST_OK);
      add_row(KIND_LIST,  '0, 6'd4, 0, ST_OK);
      add_row(KIND_ALLOC, 20'd1, 6'd0, 1, ST_SHORT);
      add_row(KIND_FREE,  '0, 6'd4, 0, ST_OK);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            pool_beat_type e;
            send_cmd(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].pid);
            e = expected_beats[expected_beats.size() - 1];
            if (e.status !== dir_rows[i].st) begin
               $error("status expected %0d actual %0d", dir_rows[i].st, e.status);
               errors++;
            end
         end else send_cmd(dir_rows[i].kind, dir_rows[i].size, dir_rows[i].pid);
      end
      drain();

      // no descriptor left: 64 single-block packets then one more
      csr_write(16'd65535);
      for (int i = 0; i < NUM_BLOCKS; i++) send_cmd(KIND_ALLOC, 20'd1, '0);
      send_cmd(KIND_ALLOC, 20'd1, '0);
      for (int i = 0; i < NUM_BLOCKS; i++) send_cmd(KIND_FREE, '0, IDX_W'(i));
      drain();

      sizes[0] = 16'd0; sizes[1] = 16'd1; sizes[2] = 16'd97; sizes[3] = 16'd64;
      // sender busy / receiver slack, then swapped, then full speed
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 36 : (ph == 1) ? 81 : 0;
         recv_idle = (ph == 0) ? 81 : (ph == 1) ? 36 : 0;
         csr_write(sizes[ph]);
         if (ph == 2) begin
            // long receiver hold while requests keep coming
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(negedge clock);
                  hold_rsp = 0;
               end
               random_phase(20);
            join
         end
         random_phase(25);
         drain();
      end
      csr_write(sizes[3]);
      random_phase(30);
      drain();

      if (errors == 0 && expected_beats.size() == 0) begin
         $display("PASS chained_block_pool_manager");
      end else begin
         $display("FAIL chained_block_pool_manager");
      end
      $finish;
   end
endmodule
